// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== design/edf_pkg.sv =====
// shared types and constants of the edf daily capacity scheduler
// no dependencies
package edf_pkg;
  localparam int KeyW = 32;
  localparam int FieldW = 16;
  localparam int CapW = 7;
  localparam int MaxServe = 64;
  localparam int ServeIdxW = 6;

  typedef enum logic {
    MODE_ADD = 1'b0,
    MODE_END_DAY = 1'b1
  } mode_t;

  // one classified item handed from front to back
  typedef struct packed {
    mode_t mode;
    logic [FieldW-1:0] deadline;
    logic [FieldW-1:0] task_id;
  } cmd_t;
endpackage

// ===== design/edf_cmd_queue.sv =====
// front part: accepts items, classifies them and queues them for the heap engine
// depends on edf_pkg
module edf_cmd_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [31:0] in_tdata,  // deadline [15:0], task_id [31:16]
  input  logic in_tuser,         // mode
  output logic cmd_valid,
  input  logic cmd_ready,
  output edf_pkg::cmd_t cmd
);
  import edf_pkg::*;

  cmd_t q_r [2];
  logic rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic push, pop;
  cmd_t in_cmd;

  // classify the incoming item
  always_comb begin
    in_cmd.mode = (in_tuser == 1'b1) ? MODE_END_DAY : MODE_ADD;
    in_cmd.deadline = in_tdata[15:0];
    in_cmd.task_id = in_tdata[31:16];
  end

  assign in_tready = (fill_r != 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd = q_r[rd_ptr_r];
  assign push = in_tvalid && in_tready;
  assign pop = cmd_valid && cmd_ready;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end
endmodule

// ===== design/edf_heap_engine.sv =====
// back part: binary min-heap in a memory, day service, result buffer and output register
// depends on edf_pkg
module edf_heap_engine #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  edf_pkg::cmd_t cmd,
  input  logic [edf_pkg::CapW-1:0] capacity,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [15:0] out_tdata,  // served_id
  output logic out_tlast,         // last
  output logic [2:0] out_tuser    // has_task, missed, overflowed
);
  import edf_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNTW = $clog2(STORE_DEPTH + 1);
  localparam int XW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH_RD, S_PUSH_CMP, S_PUSH_FIN,
    S_POP_CHK, S_POP_TOP, S_POP_LAST, S_POP_C1, S_POP_C2, S_POP_C2W,
    S_POP_DEC, S_POP_FIN, S_MISS_RD, S_MISS_CHK, S_EMIT_RD, S_EMIT_LD
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt, child_r, child_nxt;
  logic [KeyW-1:0] key_r, key_nxt, cv_r, cv_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CapW-1:0] served_r, served_nxt, cap_r, cap_nxt, k_r, k_nxt;
  logic [FieldW-1:0] day_r, day_nxt;
  logic missed_r, missed_nxt, ovf_r, ovf_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt, out_has_r, out_has_nxt;
  logic out_miss_r, out_miss_nxt, out_ovf_r, out_ovf_nxt;
  logic [FieldW-1:0] out_id_r, out_id_nxt;

  logic [KeyW-1:0] mem [STORE_DEPTH];
  logic [KeyW-1:0] mem_q;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [KeyW-1:0] mem_wd;

  logic [FieldW-1:0] rbuf [MaxServe];
  logic [FieldW-1:0] rbuf_q;
  logic rbuf_we, rbuf_re;
  logic [ServeIdxW-1:0] rbuf_wa, rbuf_ra;

  logic [XW-1:0] child_x, count_x;
  logic [AW-1:0] parent;
  logic out_free;

  assign child_x = XW'({pos_r, 1'b1});
  assign count_x = XW'(count_r);
  assign parent = AW'((pos_r - AW'(1)) >> 1);
  assign out_free = !out_valid_r || out_tready;
  assign cmd_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    child_nxt = child_r;
    key_nxt = key_r;
    cv_nxt = cv_r;
    count_nxt = count_r;
    served_nxt = served_r;
    cap_nxt = cap_r;
    k_nxt = k_r;
    day_nxt = day_r;
    missed_nxt = missed_r;
    ovf_nxt = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt = out_last_r;
    out_has_nxt = out_has_r;
    out_miss_nxt = out_miss_r;
    out_ovf_nxt = out_ovf_r;
    out_id_nxt = out_id_r;
    mem_we = 1'b0;
    mem_wa = pos_r;
    mem_wd = key_r;
    mem_re = 1'b0;
    mem_ra = '0;
    rbuf_we = 1'b0;
    rbuf_wa = served_r[ServeIdxW-1:0];
    rbuf_re = 1'b0;
    rbuf_ra = k_r[ServeIdxW-1:0];
    case (state_r)
      // take a command from the queue
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.mode == MODE_ADD) begin
            if (count_r == CNTW'(STORE_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              key_nxt = {cmd.deadline, cmd.task_id};
              pos_nxt = AW'(count_r);
              count_nxt = count_r + CNTW'(1);
              state_nxt = (count_r == '0) ? S_PUSH_FIN : S_PUSH_RD;
            end
          end else begin
            cap_nxt = (capacity > CapW'(MaxServe)) ? CapW'(MaxServe) : capacity;
            served_nxt = '0;
            state_nxt = S_POP_CHK;
          end
        end
      end
      // sift up
      S_PUSH_RD: begin
        mem_re = 1'b1;
        mem_ra = parent;
        state_nxt = S_PUSH_CMP;
      end
      S_PUSH_CMP: begin
        if (mem_q <= key_r) begin
          state_nxt = S_PUSH_FIN;
        end else begin
          mem_we = 1'b1;
          mem_wd = mem_q;
          pos_nxt = parent;
          state_nxt = (parent == '0) ? S_PUSH_FIN : S_PUSH_RD;
        end
      end
      S_PUSH_FIN: begin
        mem_we = 1'b1;
        state_nxt = S_IDLE;
      end
      // serve loop
      S_POP_CHK: begin
        if ((served_r < cap_r) && (count_r != '0)) begin
          mem_re = 1'b1;
          mem_ra = '0;
          state_nxt = S_POP_TOP;
        end else begin
          state_nxt = S_MISS_RD;
        end
      end
      S_POP_TOP: begin
        rbuf_we = 1'b1;
        served_nxt = served_r + CapW'(1);
        count_nxt = count_r - CNTW'(1);
        if (count_r == CNTW'(1)) begin
          state_nxt = S_POP_CHK;
        end else begin
          mem_re = 1'b1;
          mem_ra = AW'(count_r - CNTW'(1));
          state_nxt = S_POP_LAST;
        end
      end
      S_POP_LAST: begin
        key_nxt = mem_q;
        pos_nxt = '0;
        state_nxt = S_POP_C1;
      end
      // sift down, one level per pass
      S_POP_C1: begin
        if (child_x >= count_x) begin
          state_nxt = S_POP_FIN;
        end else begin
          child_nxt = AW'(child_x);
          mem_re = 1'b1;
          mem_ra = AW'(child_x);
          state_nxt = S_POP_C2;
        end
      end
      S_POP_C2: begin
        cv_nxt = mem_q;
        if ((XW'(child_r) + XW'(1)) < count_x) begin
          mem_re = 1'b1;
          mem_ra = child_r + AW'(1);
          state_nxt = S_POP_C2W;
        end else begin
          state_nxt = S_POP_DEC;
        end
      end
      S_POP_C2W: begin
        if (mem_q < cv_r) begin
          cv_nxt = mem_q;
          child_nxt = child_r + AW'(1);
        end
        state_nxt = S_POP_DEC;
      end
      S_POP_DEC: begin
        if (key_r <= cv_r) begin
          state_nxt = S_POP_FIN;
        end else begin
          mem_we = 1'b1;
          mem_wd = cv_r;
          pos_nxt = child_r;
          state_nxt = S_POP_C1;
        end
      end
      S_POP_FIN: begin
        mem_we = 1'b1;
        state_nxt = S_POP_CHK;
      end
      // deadline check on the earliest remaining task
      S_MISS_RD: begin
        k_nxt = '0;
        if (count_r != '0) begin
          mem_re = 1'b1;
          mem_ra = '0;
          state_nxt = S_MISS_CHK;
        end else begin
          day_nxt = day_r + FieldW'(1);
          state_nxt = S_EMIT_RD;
        end
      end
      S_MISS_CHK: begin
        if ({1'b0, mem_q[31:16]} <= ({1'b0, day_r} + 17'd1)) begin
          missed_nxt = 1'b1;
        end
        day_nxt = day_r + FieldW'(1);
        state_nxt = S_EMIT_RD;
      end
      // results of the day, flags captured with each result
      S_EMIT_RD: begin
        if (served_r == '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_id_nxt = '0;
            out_has_nxt = 1'b0;
            out_last_nxt = 1'b1;
            out_miss_nxt = missed_r;
            out_ovf_nxt = ovf_r;
            state_nxt = S_IDLE;
          end
        end else begin
          rbuf_re = 1'b1;
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt = rbuf_q;
          out_has_nxt = 1'b1;
          out_last_nxt = ((k_r + CapW'(1)) == served_r);
          out_miss_nxt = missed_r;
          out_ovf_nxt = ovf_r;
          k_nxt = k_r + CapW'(1);
          state_nxt = ((k_r + CapW'(1)) == served_r) ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      day_r <= '0;
      missed_r <= 1'b0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_miss_r <= 1'b0;
      out_ovf_r <= 1'b0;
      served_r <= '0;
      cap_r <= '0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      day_r <= day_nxt;
      missed_r <= missed_nxt;
      ovf_r <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      out_miss_r <= out_miss_nxt;
      out_ovf_r <= out_ovf_nxt;
      served_r <= served_nxt;
      cap_r <= cap_nxt;
      k_r <= k_nxt;
    end
    pos_r <= pos_nxt;
    child_r <= child_nxt;
    key_r <= key_nxt;
    cv_r <= cv_nxt;
    out_last_r <= out_last_nxt;
    out_has_r <= out_has_nxt;
    out_id_r <= out_id_nxt;
  end

  // heap memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // served id buffer
  always_ff @(posedge clk) begin
    if (rbuf_we) begin
      rbuf[rbuf_wa] <= mem_q[FieldW-1:0];
    end
    if (rbuf_re) begin
      rbuf_q <= rbuf[rbuf_ra];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_id_r;
  assign out_tlast = out_last_r;
  assign out_tuser = {out_ovf_r, out_miss_r, out_has_r};
endmodule

// ===== design/edf_daily_capacity_scheduler_unit.sv =====
// top level of the edf daily capacity scheduler
// depends on edf_pkg, edf_cmd_queue, edf_heap_engine and assert_macros.svh
// An add item sifts up one heap level per pass, at most log2 of STORE_DEPTH levels; an add
// to a full heap is dropped. An end-of-day item pops each served task and sifts the heap
// down one level per pass, then checks the deadline of the earliest remaining task and
// emits one result per served task (one empty result for an empty day); the heap memory
// has a single read port, so these steps take turns on it. A two-entry item queue lets
// input items arrive while a day is being served, and the output register holds a result
// while the next is read.
`include "assert_macros.svh"
module edf_daily_capacity_scheduler_unit #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [31:0] in_tdata,  // deadline [15:0], task_id [31:16]
  input  logic in_tuser,         // mode
  output logic out_tvalid,
  input  logic out_tready,
  output logic [15:0] out_tdata, // served_id
  output logic out_tlast,        // last
  output logic [2:0] out_tuser,  // has_task [0], missed [1], overflowed [2]
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [edf_pkg::CapW-1:0] cfg_data  // capacity_per_day
);
  import edf_pkg::*;

  logic [CapW-1:0] cap_r;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // capacity register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapW'(1);
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  edf_cmd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  edf_heap_engine #(.STORE_DEPTH(STORE_DEPTH)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .capacity(cap_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  // checks
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_SAME(a_empty_is_last, clk, rst_n, out_tvalid && !out_tuser[0], out_tlast && out_tdata == 16'd0)
  `ASSERT_NEXT(a_ovf_sticky, clk, rst_n, out_tvalid && out_tuser[2], !out_tvalid || out_tuser[2])
endmodule

// ===== bench/edf_daily_capacity_scheduler_unit_tb.sv =====
// self-checking bench for the edf daily capacity scheduler
// depends on edf_pkg and the edf_daily_capacity_scheduler_unit design files
// a directed table, capacity corner cases, then random add and end-of-day items checked against a local model
`timescale 1ns / 100ps
module edf_daily_capacity_scheduler_unit_tb;
  import edf_pkg::*;

  localparam int Depth = 1024;
  localparam int WatchLimit = 200000;

  typedef struct {
    logic [15:0] served_id;
    logic has_task;
    logic last;
    logic missed;
    logic overflowed;
  } slot_t;

  typedef struct {
    mode_t mode;
    logic [15:0] deadline;
    logic [15:0] task_id;
    bit typed;
    logic [15:0] want_id;
    logic want_has;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [15:0] out_tdata;
  logic out_tlast;
  logic [2:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CapW-1:0] cfg_data;

  // model state
  logic [31:0] pend[$];
  logic [15:0] day_cnt;
  logic miss_flag;
  logic ovf_flag;
  logic [CapW-1:0] cap_reg;

  slot_t expected_slots[$];
  int errors;
  int idle_cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int slots_seen;
  int days_sent;
  row_t dir_rows[$];

  edf_daily_capacity_scheduler_unit #(.STORE_DEPTH(Depth)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // smallest key in the pending list, by index
  function automatic int min_pos();
    int best;
    best = 0;
    for (int i = 1; i < pend.size(); i++)
      if (pend[i] < pend[best]) best = i;
    return best;
  endfunction

  // schedule one item and queue the slots it yields
  task automatic schedule_item(mode_t mode, logic [15:0] dl, logic [15:0] id);
    int cap;
    int p;
    logic [15:0] ids[$];
    slot_t s;
    if (mode == MODE_ADD) begin
      if (pend.size() >= Depth) ovf_flag = 1'b1;
      else pend.insert(pend.size(), {dl, id});
    end else begin
      cap = (cap_reg > MaxServe) ? MaxServe : cap_reg;
      while (ids.size() < cap && pend.size() > 0) begin
        p = min_pos();
        ids.insert(ids.size(), pend[p][15:0]);
        pend.delete(p);
      end
      if (pend.size() > 0 && {1'b0, pend[min_pos()][31:16]} <= {1'b0, day_cnt} + 17'd1)
        miss_flag = 1'b1;
      day_cnt = day_cnt + 16'd1;
      if (ids.size() == 0) begin
        s = '{16'd0, 1'b0, 1'b1, miss_flag, ovf_flag};
        expected_slots.insert(expected_slots.size(), s);
      end
      foreach (ids[k]) begin
        s = '{ids[k], 1'b1, k == ids.size() - 1, miss_flag, ovf_flag};
        expected_slots.insert(expected_slots.size(), s);
      end
    end
  endtask

  // valid stays high between back to back items; it drops only while idling
  task automatic send_item(mode_t mode, logic [15:0] dl, logic [15:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {id, dl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    schedule_item(mode, dl, id);
    items_sent++;
    if (mode == MODE_END_DAY) days_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_slots.size() > 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // write capacity while idle
  task automatic write_cap(logic [CapW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random traffic: mostly adds with near deadlines, some end-of-day items
  task automatic random_burst(int n);
    logic [15:0] dl;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) send_item(MODE_END_DAY, 16'($urandom), 16'($urandom));
      else begin
        dl = ($urandom_range(9) == 0) ? 16'($urandom) : day_cnt + 16'($urandom_range(4));
        send_item(MODE_ADD, dl, ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom));
      end
    end
  endtask

  // receiver with random stalls, compares each slot
  always @(negedge clk) begin
    out_tready <= (rst_n && $urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    slot_t e;
    if (rst_n && out_tvalid && out_tready) begin
      slots_seen++;
      if (expected_slots.size() == 0) begin
        $error("unexpected result served_id=%0h", out_tdata);
        errors++;
      end else begin
        e = expected_slots.pop_front();
        if (out_tdata !== e.served_id) begin
          $error("served_id expected %0h actual %0h", e.served_id, out_tdata); errors++;
        end
        if (out_tuser[0] !== e.has_task) begin
          $error("has_task expected %0b actual %0b", e.has_task, out_tuser[0]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last expected %0b actual %0b", e.last, out_tlast); errors++;
        end
        if (out_tuser[1] !== e.missed) begin
          $error("missed expected %0b actual %0b", e.missed, out_tuser[1]); errors++;
        end
        if (out_tuser[2] !== e.overflowed) begin
          $error("overflowed expected %0b actual %0b", e.overflowed, out_tuser[2]); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog: no progress");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    row_t r;
    logic [15:0] want;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_valid = 1'b0; cfg_data = '0; out_tready = 1'b0;
    errors = 0; items_sent = 0; slots_seen = 0; days_sent = 0;
    send_idle_pct = 16; recv_idle_pct = 52;
    pend.delete(); day_cnt = 0; miss_flag = 0; ovf_flag = 0; cap_reg = 1;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows: empty day after reset, extremes, ties, duplicates
    dir_rows = '{
      '{MODE_END_DAY, 16'hffff, 16'hffff, 1'b1, 16'd0, 1'b0},
      '{MODE_ADD, 16'hffff, 16'hffff, 1'b0, 16'd0, 1'b0},
      '{MODE_ADD, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0},
      '{MODE_END_DAY, 16'd0, 16'd0, 1'b1, 16'h0000, 1'b1},
      '{MODE_ADD, 16'd5, 16'd9, 1'b0, 16'd0, 1'b0},
      '{MODE_ADD, 16'd5, 16'd3, 1'b0, 16'd0, 1'b0},
      '{MODE_ADD, 16'd5, 16'd3, 1'b0, 16'd0, 1'b0},
      '{MODE_ADD, 16'd2, 16'haaaa, 1'b0, 16'd0, 1'b0},
      '{MODE_ADD, 16'd2, 16'h5555, 1'b0, 16'd0, 1'b0},
      '{MODE_END_DAY, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0}
    };
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      // typed rows hold single-slot results: compare the newest prediction
      send_item(r.mode, r.deadline, r.task_id);
      if (r.typed && expected_slots.size() > 0) begin
        want = expected_slots[$].served_id;
        if (want !== r.want_id || expected_slots[$].has_task !== r.want_has) begin
          $error("table row %0d: model gives served_id %0h", i, want); errors++;
        end
      end
    end
    // max capacity, saturation above 64 and zero capacity
    write_cap(7'd64);
    send_item(MODE_END_DAY, 16'd0, 16'd0);
    write_cap(7'd127);
    send_item(MODE_ADD, 16'd1, 16'd1);
    send_item(MODE_END_DAY, 16'd0, 16'd0);
    write_cap(7'd0);
    send_item(MODE_ADD, 16'd1, 16'd2);
    send_item(MODE_END_DAY, 16'd0, 16'd0);

    // random phases through several capacities and idle patterns
    write_cap(7'd3);
    random_burst(60);
    drain();
    send_idle_pct = 52; recv_idle_pct = 16;
    write_cap(7'($urandom_range(1, 64)));
    random_burst(60);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_cap(7'd1);
    random_burst(50);
    send_item(MODE_END_DAY, 16'd0, 16'd0);

    drain();
    $display("sent %0d items (%0d day ends), checked %0d results", items_sent, days_sent,
             slots_seen);
    $display("covered capacities 0, 1, 3, 64, 127 with ties, duplicates and late deadlines");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== edf_daily_capacity_scheduler_unit.f =====
+incdir+design
design/edf_pkg.sv
design/edf_cmd_queue.sv
design/edf_heap_engine.sv
design/edf_daily_capacity_scheduler_unit.sv
bench/edf_daily_capacity_scheduler_unit_tb.sv
